FILE: rtl/ufr_pkg.sv
`timescale 1ns / 1ps

package ufr_pkg;

   // Operation codes on the request channel
   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_BYTE  = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   // Register indexes on the csr channel
   localparam logic [1:0] CSR_FRAME_MARKER  = 2'd0;
   localparam logic [1:0] CSR_FIRST_TIMEOUT = 2'd1;
   localparam logic [1:0] CSR_BYTE_TIMEOUT  = 2'd2;

   // Register reset values
   localparam logic [31:0] FRAME_MARKER_RST  = 32'd0;
   localparam logic [22:0] FIRST_TIMEOUT_RST = 23'd20000;
   localparam logic [15:0] BYTE_TIMEOUT_RST  = 16'd100;

   // Frame status codes
   localparam logic [2:0] STATUS_OK            = 3'd0;
   localparam logic [2:0] STATUS_FIRST_TIMEOUT = 3'd1;
   localparam logic [2:0] STATUS_BYTE_TIMEOUT  = 3'd2;
   localparam logic [2:0] STATUS_HDR_LIMIT     = 3'd3;
   localparam logic [2:0] STATUS_CRC_ERROR     = 3'd4;

   // Result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   // Flag byte that restarts the flag match at its second byte
   localparam logic [7:0]  FLAG_RESYNC_BYTE = 8'hEF;
   localparam logic [15:0] CRC_POLY         = 16'h1021;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] rx_byte;
   } req_word_type;

   typedef struct packed {
      logic        kind;
      logic        last;
      logic [7:0]  payload_byte;
      logic [9:0]  byte_index;
      logic [2:0]  status;
      logic [15:0] frame_type;
      logic [10:0] frame_size;
      logic [15:0] received_check;
      logic [15:0] computed_crc;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]  reg_index;
      logic [31:0] wr_data;
   } csr_word_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] rx_byte;
   } cmd_word_type;

   typedef struct packed {
      logic [31:0] frame_marker;
      logic [22:0] first_timeout_ms;
      logic [15:0] byte_timeout_ms;
   } cfg_type;

   // CRC-16-CCITT, MSB first, one byte
   function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

FILE: rtl/ufr_chan_if.sv
`timescale 1ns / 1ps

// Valid/ready channel carrying one word per handshake
interface ufr_chan_if #(parameter type word_type = logic);
   logic     valid;
   logic     ready;
   word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ufr_front.sv
`timescale 1ns / 1ps

module ufr_front import ufr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ufr_chan_if.sink   req_if,
   ufr_chan_if.source cmd_if
);

   localparam logic [1:0] QUEUE_DEPTH = 2'd2;

   cmd_word_type q_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         accept, known_op, push, pop;
   cmd_word_type entry;

   // classify: unknown operations are dropped at the door
   assign req_if.ready = (count_ff != QUEUE_DEPTH);
   assign accept       = req_if.valid && req_if.ready;
   assign known_op     = (req_if.data.operation == OP_START) ||
                         (req_if.data.operation == OP_BYTE)  ||
                         (req_if.data.operation == OP_TICK);
   assign push         = accept && known_op;
   assign pop          = cmd_if.valid && cmd_if.ready;

   always_comb begin
      entry.op      = op_type'(req_if.data.operation);
      entry.rx_byte = req_if.data.rx_byte;
   end

   assign cmd_if.valid = (count_ff != 2'd0);
   assign cmd_if.data  = q_ff[rd_ptr_ff];

   // queue bookkeeping
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

FILE: rtl/ufr_back.sv
`timescale 1ns / 1ps

module ufr_back import ufr_pkg::*; #(
   parameter int PAYLOAD_MAX       = 1024,
   parameter int HEADER_BYTE_LIMIT = 101
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   ufr_chan_if.sink   cmd_if,
   ufr_chan_if.source rsp_if
);

   localparam int          PCW       = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX + 1) : 1;
   localparam logic [15:0] SIZE_MAX  = 16'(PAYLOAD_MAX);
   localparam logic [6:0]  HDR_LIMIT = 7'(HEADER_BYTE_LIMIT);

   // header byte positions
   localparam logic [3:0] POS_FLAG_END = 4'd4;
   localparam logic [3:0] POS_SIZE_LO  = 4'd4;
   localparam logic [3:0] POS_SIZE_HI  = 4'd5;
   localparam logic [3:0] POS_CHK_LO   = 4'd6;
   localparam logic [3:0] POS_CHK_HI   = 4'd7;
   localparam logic [3:0] POS_TYPE_LO  = 4'd8;
   localparam logic [3:0] POS_TYPE_HI  = 4'd9;
   localparam logic [3:0] POS_LAST     = 4'd11;
   localparam logic [3:0] HEADER_LEN   = 4'd12;

   localparam int         RES_DEPTH = 4;
   localparam logic [2:0] RES_ROOM  = 3'(RES_DEPTH - 2);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HEADER,
      PH_PAYLOAD
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [3:0]       pos_ff, pos_in;
   logic             restart_ff, restart_in;
   logic [6:0]       hcnt_ff, hcnt_in;
   logic [15:0]      size_ff, size_in;
   logic [15:0]      check_ff, check_in;
   logic [15:0]      type_ff, type_in;
   logic [PCW-1:0]   pcount_ff, pcount_in;
   logic [15:0]      crc_ff, crc_in;
   logic [22:0]      idle_ff, idle_in;

   rsp_word_type     res_q_ff [RES_DEPTH];
   logic [1:0]       res_wr_ff, res_rd_ff;
   logic [2:0]       res_count_ff, res_count_in;

   logic             go, pop;
   logic             emit_payload, emit_finish, header_done;
   logic [2:0]       fin_status;
   logic [3:0]       pos;
   logic [7:0]       b, want;
   logic [23:0]      idle_next;
   logic [22:0]      limit;
   logic             first_wait;
   rsp_word_type     pay_word, fin_word;
   logic             push0, push1;

   // take a command only when two result slots are free
   assign cmd_if.ready = (res_count_ff <= RES_ROOM);
   assign go           = cmd_if.valid && cmd_if.ready;
   assign b            = cmd_if.data.rx_byte;

   // frame engine next state
   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      restart_in   = restart_ff;
      hcnt_in      = hcnt_ff;
      size_in      = size_ff;
      check_in     = check_ff;
      type_in      = type_ff;
      pcount_in    = pcount_ff;
      crc_in       = crc_ff;
      idle_in      = idle_ff;
      emit_payload = 1'b0;
      emit_finish  = 1'b0;
      header_done  = 1'b0;
      fin_status   = STATUS_OK;
      pos          = pos_ff;
      want         = 8'd0;
      idle_next    = {1'b0, idle_ff} + 24'd1;
      first_wait   = (phase_ff == PH_HEADER) && (pos_ff == 4'd0);
      limit        = first_wait ? cfg.first_timeout_ms : {7'd0, cfg.byte_timeout_ms};

      if (go) begin
         if (cmd_if.data.op == OP_START) begin
            phase_in   = PH_HEADER;
            pos_in     = 4'd0;
            restart_in = 1'b0;
            hcnt_in    = 7'd0;
            size_in    = 16'd0;
            check_in   = 16'd0;
            type_in    = 16'd0;
            pcount_in  = '0;
            crc_in     = 16'd0;
            idle_in    = 23'd0;
         end else if (phase_ff != PH_IDLE) begin
            if (cmd_if.data.op == OP_TICK) begin
               // silence timer
               idle_in = idle_next[22:0];
               if (idle_next >= {1'b0, limit}) begin
                  emit_finish = 1'b1;
                  fin_status  = first_wait ? STATUS_FIRST_TIMEOUT : STATUS_BYTE_TIMEOUT;
               end
            end else if (phase_ff == PH_HEADER) begin
               // header hunt
               idle_in    = 23'd0;
               hcnt_in    = hcnt_ff + 7'd1;
               pos        = restart_ff ? 4'd0 : pos_ff;
               pos_in     = pos;
               restart_in = 1'b0;
               if (pos < POS_FLAG_END) begin
                  want = cfg.frame_marker[{pos[1:0], 3'b000} +: 8];
                  if (b == want) begin
                     pos_in = pos + 4'd1;
                  end else if (b == FLAG_RESYNC_BYTE) begin
                     pos_in = 4'd1;
                  end else begin
                     restart_in = 1'b1;
                  end
               end else begin
                  case (pos)
                     POS_SIZE_LO: size_in[7:0]   = b;
                     POS_SIZE_HI: size_in[15:8]  = b;
                     POS_CHK_LO:  check_in[7:0]  = b;
                     POS_CHK_HI:  check_in[15:8] = b;
                     POS_TYPE_LO: type_in[7:0]   = b;
                     POS_TYPE_HI: type_in[15:8]  = b;
                     default: ;
                  endcase
                  if (pos == POS_SIZE_HI && size_in > SIZE_MAX) begin
                     restart_in = 1'b1;
                  end else if (pos == POS_LAST) begin
                     pos_in      = HEADER_LEN;
                     header_done = 1'b1;
                     if (size_in == 16'd0) begin
                        emit_finish = 1'b1;
                        fin_status  = (check_in == 16'd0) ? STATUS_OK : STATUS_CRC_ERROR;
                     end else begin
                        phase_in  = PH_PAYLOAD;
                        pcount_in = '0;
                        crc_in    = 16'd0;
                     end
                  end else begin
                     pos_in = pos + 4'd1;
                  end
               end
               if (!header_done && hcnt_in >= HDR_LIMIT) begin
                  emit_finish = 1'b1;
                  fin_status  = STATUS_HDR_LIMIT;
               end
            end else begin
               // payload byte
               idle_in      = 23'd0;
               crc_in       = crc16_byte(crc_ff, b);
               pcount_in    = pcount_ff + PCW'(1);
               emit_payload = 1'b1;
               if (17'(pcount_in) >= {1'b0, size_ff}) begin
                  emit_finish = 1'b1;
                  fin_status  = (crc_in == check_ff) ? STATUS_OK : STATUS_CRC_ERROR;
               end
            end
            if (emit_finish) begin
               phase_in = PH_IDLE;
            end
         end
      end
   end

   // result words
   always_comb begin
      pay_word.kind           = KIND_PAYLOAD;
      pay_word.last           = !emit_finish;
      pay_word.payload_byte   = b;
      pay_word.byte_index     = 10'(pcount_ff);
      pay_word.status         = STATUS_OK;
      pay_word.frame_type     = type_in;
      pay_word.frame_size     = size_in[10:0];
      pay_word.received_check = check_in;
      pay_word.computed_crc   = crc_in;

      fin_word.kind           = KIND_STATUS;
      fin_word.last           = 1'b1;
      fin_word.payload_byte   = 8'd0;
      fin_word.byte_index     = 10'd0;
      fin_word.status         = fin_status;
      fin_word.frame_type     = type_in;
      fin_word.frame_size     = size_in[10:0];
      fin_word.received_check = check_in;
      fin_word.computed_crc   = crc_in;
   end

   assign push0 = emit_payload || emit_finish;
   assign push1 = emit_payload && emit_finish;

   // engine state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         pos_ff     <= 4'd0;
         restart_ff <= 1'b0;
         hcnt_ff    <= 7'd0;
         size_ff    <= 16'd0;
         check_ff   <= 16'd0;
         type_ff    <= 16'd0;
         pcount_ff  <= '0;
         crc_ff     <= 16'd0;
         idle_ff    <= 23'd0;
      end else begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         restart_ff <= restart_in;
         hcnt_ff    <= hcnt_in;
         size_ff    <= size_in;
         check_ff   <= check_in;
         type_ff    <= type_in;
         pcount_ff  <= pcount_in;
         crc_ff     <= crc_in;
         idle_ff    <= idle_in;
      end
   end

   // result buffer: up to two words in, one word out per cycle while rsp_if is ready
   assign rsp_if.valid = (res_count_ff != 3'd0);
   assign rsp_if.data  = res_q_ff[res_rd_ff];
   assign pop          = rsp_if.valid && rsp_if.ready;

   always_comb begin
      res_count_in = res_count_ff + 3'(push0) + 3'(push1) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_wr_ff    <= 2'd0;
         res_rd_ff    <= 2'd0;
         res_count_ff <= 3'd0;
      end else begin
         res_wr_ff    <= res_wr_ff + 2'(push0) + 2'(push1);
         res_rd_ff    <= res_rd_ff + 2'(pop);
         res_count_ff <= res_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         res_q_ff[res_wr_ff] <= push1 ? pay_word : (emit_payload ? pay_word : fin_word);
      end
      if (push1) begin
         res_q_ff[res_wr_ff + 2'd1] <= fin_word;
      end
   end

`ifndef ASSERT_OFF
   a_res_no_overflow: assert property (@(posedge clock) disable iff (reset)
      res_count_ff <= 3'(RES_DEPTH))
      else $error("result buffer overflow");

   a_payload_size: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (size_ff != 16'd0 && size_ff <= SIZE_MAX))
      else $error("payload phase with bad size");

   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (17'(pcount_ff) < {1'b0, size_ff}))
      else $error("payload count past frame size");

   a_header_pos: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HEADER) |-> (pos_ff <= POS_LAST))
      else $error("header position out of range");

   a_payload_word_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.data.kind == KIND_PAYLOAD) |->
      (rsp_if.data.status == STATUS_OK))
      else $error("payload word carries a status");
`endif

endmodule

FILE: rtl/uart_frame_receiver_crc16.sv
`timescale 1ns / 1ps
// Requests pass a command queue in ufr_front; results leave a four-entry result buffer.
// Throughput: one request word per cycle while the command queue has room; the frame engine
// handles a byte (CRC included) as its command is taken, and a payload byte that ends a frame
// gives two result words, drained from that buffer one per cycle while rsp_if is ready.
// Reset: synchronous, active high; returns to idle and loads the register defaults.

module uart_frame_receiver_crc16 import ufr_pkg::*; #(
   parameter int PAYLOAD_MAX       = 1024,
   parameter int HEADER_BYTE_LIMIT = 101
) (
   input  logic       clock,
   input  logic       reset,
   ufr_chan_if.sink   req_if,
   ufr_chan_if.source rsp_if,
   ufr_chan_if.sink   csr_if
);

   cfg_type cfg_ff;
   logic    csr_wr;

   ufr_chan_if #(.word_type(cmd_word_type)) cmd_if ();

   // configuration registers
   assign csr_if.ready = 1'b1;
   assign csr_wr       = csr_if.valid && csr_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_marker     <= FRAME_MARKER_RST;
         cfg_ff.first_timeout_ms <= FIRST_TIMEOUT_RST;
         cfg_ff.byte_timeout_ms  <= BYTE_TIMEOUT_RST;
      end else if (csr_wr) begin
         case (csr_if.data.reg_index)
            CSR_FRAME_MARKER:  cfg_ff.frame_marker     <= csr_if.data.wr_data;
            CSR_FIRST_TIMEOUT: cfg_ff.first_timeout_ms <= csr_if.data.wr_data[22:0];
            CSR_BYTE_TIMEOUT:  cfg_ff.byte_timeout_ms  <= csr_if.data.wr_data[15:0];
            default: ;
         endcase
      end
   end

   ufr_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .cmd_if (cmd_if)
   );

   ufr_back #(
      .PAYLOAD_MAX       (PAYLOAD_MAX),
      .HEADER_BYTE_LIMIT (HEADER_BYTE_LIMIT)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .cmd_if (cmd_if),
      .rsp_if (rsp_if)
   );

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import ufr_pkg::*;

   localparam int MAX_PAYLOAD    = 1024;
   localparam int HDR_BYTE_LIMIT = 101;
   localparam int HOLD_CYCLES    = 300;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   typedef enum logic [1:0] {FR_IDLE, FR_HEADER, FR_PAYLOAD} frame_phase_type;
   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   // One line of the opening sequence: a request word or a register write
   typedef struct {
      row_kind_type kind;
      logic [1:0]   code;
      logic [31:0]  value;
      bit           check_end;
      logic [2:0]   want_status;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   ufr_chan_if #(.word_type(req_word_type)) req_ch ();
   ufr_chan_if #(.word_type(rsp_word_type)) rsp_ch ();
   ufr_chan_if #(.word_type(csr_word_type)) csr_ch ();

   uart_frame_receiver_crc16 u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Register copies
   logic [31:0] flag_reg;
   logic [22:0] first_limit;
   logic [15:0] byte_limit;

   // Frame tracking state
   frame_phase_type fr_phase;
   int              hdr_pos;
   bit              resync_pend;
   logic [6:0]      hdr_count;
   logic [15:0]     size_fld;
   logic [15:0]     check_fld;
   logic [15:0]     type_fld;
   int              pay_count;
   logic [15:0]     crc_acc;
   logic [31:0]     quiet_ms;

   rsp_word_type frame_words_due [$];
   rsp_word_type head_word;

   int          errors = 0;
   int          item_count = 0;
   int          burst_left = 0;
   bit          sender_gaps;
   int          tick_pct;
   logic [15:0] rx_pattern;
   bit          hold_request = 1'b0;
   int          hold_left = 0;

   // Opening sequence: idle noise, flag resync, a good one-byte frame, both timeouts
   stim_row_type opening_rows [0:27] = '{
      '{ROW_REQ, OP_TICK,     32'h00, 1'b0, STATUS_OK},
      '{ROW_REQ, OP_BYTE,     32'hFF, 1'b0, STATUS_OK},
      '{ROW_REQ, OP_RESERVED, 32'hFF, 1'b0, STATUS_OK},
      '{ROW_REQ, OP_START,    32'h00, 1'b0, STATUS_OK},
      '{ROW_REQ, OP_RESERVED, 32'h00, 1'b0, STATUS_OK},
      '{ROW_REQ, OP_BYTE,     32'h00, 1'b0, STATUS_OK},
      '{ROW_REQ, OP_BYTE,     32'h55, 1'b0, STATUS_OK},
      '{ROW_REQ, OP_BYTE,     32'h00, 1'b0, STATUS_OK},
      '{ROW_REQ, OP_BYTE,     32'hEF, 1'b0, STATUS_OK},
      '{ROW_REQ, OP_BYTE,     32'h00, 1'b0, STATUS_OK},
      '{ROW_REQ, OP_BYTE,     32'h00, 1'b0, STATUS_OK},
      '{ROW_REQ, OP_BYTE,     32'h00, 1'b0, STATUS_OK},
      '{ROW_REQ, OP_BYTE,     32'h01, 1'b0, STATUS_OK},
      '{ROW_REQ, OP_BYTE,     32'h00, 1'b0, STATUS_OK},
      '{ROW_REQ, OP_BYTE,     32'h00, 1'b0, STATUS_OK},
      '{ROW_REQ, OP_BYTE,     32'h00, 1'b0, STATUS_OK},
      '{ROW_REQ, OP_BYTE,     32'hFF, 1'b0, STATUS_OK},
      '{ROW_REQ, OP_BYTE,     32'hFF, 1'b0, STATUS_OK},
      '{ROW_REQ, OP_BYTE,     32'h00, 1'b0, STATUS_OK},
      '{ROW_REQ, OP_BYTE,     32'h00, 1'b0, STATUS_OK},
      '{ROW_REQ, OP_BYTE,     32'h00, 1'b1, STATUS_OK},
      '{ROW_CSR, CSR_FIRST_TIMEOUT, 32'd1, 1'b0, STATUS_OK},
      '{ROW_CSR, CSR_BYTE_TIMEOUT,  32'd1, 1'b0, STATUS_OK},
      '{ROW_REQ, OP_START,    32'h00, 1'b0, STATUS_OK},
      '{ROW_REQ, OP_TICK,     32'h00, 1'b1, STATUS_FIRST_TIMEOUT},
      '{ROW_REQ, OP_START,    32'h00, 1'b0, STATUS_OK},
      '{ROW_REQ, OP_BYTE,     32'h00, 1'b0, STATUS_OK},
      '{ROW_REQ, OP_TICK,     32'h00, 1'b1, STATUS_BYTE_TIMEOUT}
   };

   // CRC-16-CCITT, one bit of data per step, MSB first
   function automatic logic [15:0] ccitt_step(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = acc;
      for (int i = 7; i >= 0; i--) begin
         fb = r[15] ^ b[i];
         r = {r[14:0], 1'b0};
         if (fb) r = r ^ CRC_POLY;
      end
      return r;
   endfunction

   function automatic void clear_frame_state();
      hdr_pos     = 0;
      resync_pend = 1'b0;
      hdr_count   = '0;
      size_fld    = '0;
      check_fld   = '0;
      type_fld    = '0;
      pay_count   = 0;
      crc_acc     = '0;
      quiet_ms    = '0;
   endfunction

   function automatic rsp_word_type frame_word(input logic kind, input logic [7:0] b,
                                               input logic [2:0] status);
      rsp_word_type r;
      r.kind           = kind;
      r.last           = 1'b0;
      r.payload_byte   = b;
      r.byte_index     = (kind == KIND_PAYLOAD) ? 10'(pay_count) : 10'd0;
      r.status         = status;
      r.frame_type     = type_fld;
      r.frame_size     = size_fld[10:0];
      r.received_check = check_fld;
      r.computed_crc   = crc_acc;
      return r;
   endfunction

   function automatic void end_frame(input logic [2:0] status);
      rsp_word_type r;
      r = frame_word(KIND_STATUS, 8'h00, status);
      r.last = 1'b1;
      frame_words_due.push_back(r);
      fr_phase = FR_IDLE;
   endfunction

   // Advance the frame state by one request word; queue the words it should produce
   task automatic track_frame(input req_word_type w, output bit counted);
      logic [1:0]   op;
      logic [7:0]   b;
      logic [31:0]  lim;
      logic [2:0]   st;
      rsp_word_type r;
      op = w.operation;
      b  = w.rx_byte;
      counted = 1'b1;
      if (op == OP_START) begin
         clear_frame_state();
         fr_phase = FR_HEADER;
      end else if (fr_phase == FR_IDLE || op == OP_RESERVED) begin
         counted = 1'b0;
      end else if (op == OP_TICK) begin
         if (quiet_ms != 32'hFFFF_FFFF) quiet_ms = quiet_ms + 1;
         if (fr_phase == FR_HEADER && hdr_pos == 0) begin
            lim = {9'd0, first_limit};
            st  = STATUS_FIRST_TIMEOUT;
         end else begin
            lim = {16'd0, byte_limit};
            st  = STATUS_BYTE_TIMEOUT;
         end
         if (quiet_ms >= lim) end_frame(st);
      end else if (fr_phase == FR_HEADER) begin
         quiet_ms  = '0;
         hdr_count = hdr_count + 7'd1;
         if (resync_pend) begin
            resync_pend = 1'b0;
            hdr_pos = 0;
         end
         if (hdr_pos < 4) begin
            if (b == flag_reg[8*hdr_pos +: 8]) hdr_pos++;
            else if (b == FLAG_RESYNC_BYTE) hdr_pos = 1;
            else resync_pend = 1'b1;
         end else begin
            case (hdr_pos)
               4: size_fld[7:0]   = b;
               5: size_fld[15:8]  = b;
               6: check_fld[7:0]  = b;
               7: check_fld[15:8] = b;
               8: type_fld[7:0]   = b;
               9: type_fld[15:8]  = b;
               default: ;
            endcase
            // oversized frame restarts the hunt
            if (hdr_pos == 5 && size_fld > MAX_PAYLOAD) begin
               resync_pend = 1'b1;
            end else begin
               hdr_pos++;
            end
         end
         if (hdr_pos >= 12) begin
            hdr_pos = 12;
            if (size_fld == 16'd0) begin
               end_frame(check_fld == 16'd0 ? STATUS_OK : STATUS_CRC_ERROR);
            end else begin
               fr_phase  = FR_PAYLOAD;
               pay_count = 0;
               crc_acc   = '0;
            end
         end else if (hdr_count >= HDR_BYTE_LIMIT) begin
            end_frame(STATUS_HDR_LIMIT);
         end
      end else begin
         // payload byte: one word, plus the status word on the last one
         quiet_ms = '0;
         crc_acc  = ccitt_step(crc_acc, b);
         r = frame_word(KIND_PAYLOAD, b, STATUS_OK);
         pay_count++;
         if (pay_count >= size_fld) begin
            frame_words_due.push_back(r);
            end_frame(crc_acc == check_fld ? STATUS_OK : STATUS_CRC_ERROR);
         end else begin
            r.last = 1'b1;
            frame_words_due.push_back(r);
         end
      end
   endtask

   // Offer one request word in bursts, with random gaps when sender_gaps is set; returns at the next falling edge
   task automatic send_req(input req_word_type w, input bit typed = 1'b0,
                           input logic [2:0] typed_status = STATUS_OK);
      int           n;
      bit           counted;
      rsp_word_type tail;
      if (burst_left == 0) begin
         if (sender_gaps) begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_ch.valid = 1'b1;
      req_ch.data  = w;
      do @(posedge clock); while (!req_ch.ready);
      n = frame_words_due.size();
      track_frame(w, counted);
      if (counted) item_count++;
      // typed rows fix kind and status of the frame end
      if (typed) begin
         if (frame_words_due.size() == n) begin
            $display("%0t: frame end expected, status %0d, none tracked", $time,
                     typed_status);
            errors++;
         end else begin
            tail = frame_words_due.pop_back();
            tail.kind   = KIND_STATUS;
            tail.last   = 1'b1;
            tail.status = typed_status;
            frame_words_due.push_back(tail);
         end
      end
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      csr_ch.valid = 1'b1;
      csr_ch.data  = {idx, value};
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_FRAME_MARKER:  flag_reg    = value;
         CSR_FIRST_TIMEOUT: first_limit = value[22:0];
         CSR_BYTE_TIMEOUT:  byte_limit  = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // Stop sending until every pending word is back, then let the pipeline empty
   task automatic settle_idle();
      req_ch.valid = 1'b0;
      burst_left = 0;
      while (frame_words_due.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic send_line_byte(input logic [7:0] b);
      if ($urandom_range(0, 99) < tick_pct)
         repeat ($urandom_range(1, 3)) send_req({OP_TICK, 8'($urandom)});
      send_req({OP_BYTE, b});
   endtask

   // One frame attempt: stray words, line noise, or a frame with random content
   task automatic send_frame(input bit big);
      logic [7:0]  body [$];
      logic [7:0]  hdr [12];
      logic [15:0] size_val, crc_val, chk_val, type_val, pad_val;
      int          pick, n, cut;
      pick = $urandom_range(0, 99);
      if (!big && pick < 8) begin
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++) send_req({2'($urandom), 8'($urandom)});
      end else if (!big && pick < 20) begin
         // long enough runs reach the header byte limit
         send_req({OP_START, 8'h00});
         n = $urandom_range(0, 130);
         for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) send_req({OP_BYTE, 8'($urandom)});
            else if (pick < 95) send_req({OP_TICK, 8'($urandom)});
            else send_req({OP_RESERVED, 8'($urandom)});
         end
      end else begin
         send_req({OP_START, 8'h00});
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 2)) send_req({OP_TICK, 8'($urandom)});
         if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
               send_line_byte(($urandom_range(0, 2) == 0) ? FLAG_RESYNC_BYTE : 8'($urandom));
         end
         pick = $urandom_range(0, 99);
         if (big) size_val = 16'(MAX_PAYLOAD);
         else if (pick < 4) size_val = 16'($urandom_range(MAX_PAYLOAD + 1, 65535));
         else if (pick < 78) size_val = 16'($urandom_range(0, 12));
         else if (pick < 96) size_val = 16'($urandom_range(13, 48));
         else size_val = 16'($urandom_range(49, 160));
         crc_val = '0;
         if (size_val <= MAX_PAYLOAD) begin
            for (int i = 0; i < size_val; i++) begin
               body.push_back(8'($urandom));
               crc_val = ccitt_step(crc_val, body[i]);
            end
         end
         chk_val  = ($urandom_range(0, 4) == 0) ? 16'($urandom) : crc_val;
         type_val = 16'($urandom);
         pad_val  = 16'($urandom);
         hdr = '{flag_reg[7:0], flag_reg[15:8], flag_reg[23:16], flag_reg[31:24],
                 size_val[7:0], size_val[15:8], chk_val[7:0], chk_val[15:8],
                 type_val[7:0], type_val[15:8], pad_val[7:0], pad_val[15:8]};
         // some frames are cut short and dropped by the next start; the big one runs whole
         n   = 12 + body.size();
         cut = (!big && $urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n;
         for (int i = 0; i < cut; i++) begin
            if (big && i == 112) hold_request = 1'b1;
            send_line_byte(i < 12 ? hdr[i] : body[i - 12]);
         end
      end
   endtask

   task automatic run_phase(input logic [31:0] flag, input logic [22:0] first_ms,
                            input logic [15:0] byte_ms, input bit gaps,
                            input logic [15:0] pattern, input int pct, input int budget,
                            input bit with_big);
      int stop_at;
      settle_idle();
      write_reg(CSR_FRAME_MARKER, flag);
      write_reg(CSR_FIRST_TIMEOUT, {9'd0, first_ms});
      write_reg(CSR_BYTE_TIMEOUT, {16'd0, byte_ms});
      sender_gaps = gaps;
      rx_pattern  = pattern;
      tick_pct    = pct;
      stop_at     = item_count + budget;
      if (with_big) send_frame(1'b1);
      while (item_count < stop_at) begin
         send_frame(1'b0);
         if ($urandom_range(0, 19) == 0) settle_idle();
      end
   endtask

   // Receiver: rotating stall pattern, or a long hold-off on request
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_ch.ready = 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES - 1;
         rsp_ch.ready = 1'b0;
      end else begin
         rsp_ch.ready = rx_pattern[0];
         rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
      end
   end

   function automatic void cmp_field(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (frame_words_due.size() == 0) begin
            $display("%0t: result word with none pending, expected nothing got %h", $time,
                     rsp_ch.data);
            errors++;
         end else begin
            head_word = frame_words_due.pop_front();
            cmp_field("kind", 32'(head_word.kind), 32'(rsp_ch.data.kind));
            cmp_field("last", 32'(head_word.last), 32'(rsp_ch.data.last));
            cmp_field("payload_byte", 32'(head_word.payload_byte),
                      32'(rsp_ch.data.payload_byte));
            cmp_field("byte_index", 32'(head_word.byte_index), 32'(rsp_ch.data.byte_index));
            cmp_field("status", 32'(head_word.status), 32'(rsp_ch.data.status));
            cmp_field("frame_type", 32'(head_word.frame_type), 32'(rsp_ch.data.frame_type));
            cmp_field("frame_size", 32'(head_word.frame_size), 32'(rsp_ch.data.frame_size));
            cmp_field("received_check", 32'(head_word.received_check),
                      32'(rsp_ch.data.received_check));
            cmp_field("computed_crc", 32'(head_word.computed_crc),
                      32'(rsp_ch.data.computed_crc));
         end
      end
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.data  = '0;
      flag_reg     = FRAME_MARKER_RST;
      first_limit  = FIRST_TIMEOUT_RST;
      byte_limit   = BYTE_TIMEOUT_RST;
      fr_phase     = FR_IDLE;
      clear_frame_state();
      rx_pattern   = 16'($urandom) | 16'h0101;
      sender_gaps  = 1'b1;
      tick_pct     = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // opening sequence, starting from reset register values
      foreach (opening_rows[i]) begin
         if (opening_rows[i].kind == ROW_CSR) begin
            settle_idle();
            write_reg(opening_rows[i].code, opening_rows[i].value);
         end else begin
            send_req({opening_rows[i].code, opening_rows[i].value[7:0]},
                     opening_rows[i].check_end, opening_rows[i].want_status);
         end
      end

      // random frames under several register settings
      run_phase(32'hFFFF_FFFF, 23'd4294967, 16'hFFFF, 1'b1, 16'hFFFF, 5, 1150, 1'b1);
      run_phase(32'h12EF_34EF, 23'd3, 16'd2, 1'b1, 16'($urandom) | 16'h0101, 8, 150, 1'b0);
      run_phase($urandom, 23'($urandom_range(1, 20)), 16'($urandom_range(1, 8)), 1'b1,
                16'($urandom) | 16'h0101, 10, 150, 1'b0);
      run_phase(32'h0000_0000, 23'd1, 16'd1, 1'b0, 16'hFFFF, 6, 150, 1'b0);
      run_phase($urandom, 23'($urandom_range(1, 10)), 16'hFFFF, 1'b1,
                16'($urandom) | 16'h0101, 10, 150, 1'b0);
      run_phase(32'hEFEF_EFEF, 23'd4294967, 16'($urandom_range(1, 5)), 1'b0,
                16'($urandom) | 16'h0101, 10, 150, 1'b0);
      settle_idle();

      if (errors == 0 && frame_words_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
